@@ rtl/pinhole_reprojection_residual_jacobian_top_defines.svh @@
// Assertion macros for the reprojection block.
`ifndef PINHOLE_REPROJECTION_RESIDUAL_JACOBIAN_TOP_DEFINES_SVH
`define PINHOLE_REPROJECTION_RESIDUAL_JACOBIAN_TOP_DEFINES_SVH

// Check a property on clk, disabled while reset is asserted.
`define PRRJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk at every edge, reset included.
`define PRRJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/prrj_pkg.sv @@
package prrj_pkg;

  localparam logic [7:0] REG_FOCAL_X  = 8'd0;
  localparam logic [7:0] REG_FOCAL_Y  = 8'd1;
  localparam logic [7:0] REG_CENTER_X = 8'd2;
  localparam logic [7:0] REG_CENTER_Y = 8'd3;

  localparam logic [1:0] PART_RES   = 2'd0;
  localparam logic [1:0] PART_POSE  = 2'd1;
  localparam logic [1:0] PART_POINT = 2'd2;

  localparam int         NUM_RES    = 10;
  localparam logic [3:0] LAST_IDX   = 4'd9;
  localparam logic [3:0] POSE_BASE  = 4'd1;
  localparam logic [3:0] POINT_BASE = 4'd7;

  typedef struct packed {
    logic [8:0][31:0] r;
    logic [31:0]      mu;
    logic [31:0]      mv;
    logic             bad;
    logic             neg_a;
    logic             neg_b;
  } div_pay_t;

endpackage

@@ rtl/pinhole_reprojection_residual_jacobian_top.sv @@
// Each input item gives ten results on the single output channel, and a new item
// is accepted only once the held item's last result is emitted; the pipeline and
// the bit-per-stage divider take one item per cycle while they are not stalled.
// Reset (rst_n, synchronous, active low): clears all valid bits and the result
// counter, and loads focal lengths of 500.0 and a zero principal point.
`include "pinhole_reprojection_residual_jacobian_top_defines.svh"

module pinhole_reprojection_residual_jacobian_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // quat_w, quat_x, quat_y, quat_z, trans_x, trans_y, trans_z,
  // point_x, point_y, point_z, meas_u, meas_v
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // value_u, value_v
  output logic [63:0]  out_tdata,
  // part, column, bad_depth, zero fill
  output logic [7:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int DW  = 32 + FRAC_BITS;
  localparam int RSH = 30 - FRAC_BITS;
  localparam logic [30:0] FOCAL_RST = 31'(64'd500 << FRAC_BITS);
  localparam logic signed [65:0] ONE   = 66'sd1 << FRAC_BITS;
  localparam logic signed [65:0] ONE30 = 66'sd1 << 30;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return $signed(v[31:0]);
  endfunction

  function automatic logic signed [31:0] mulf(input logic signed [32:0] p,
                                              input logic signed [32:0] q);
    logic signed [65:0] pr;
    pr = p * q;
    return sat32(pr >>> FRAC_BITS);
  endfunction

  function automatic logic signed [33:0] qmul(input logic signed [31:0] p,
                                              input logic signed [31:0] q);
    logic signed [63:0] pr;
    pr = p * q;
    return 34'(pr >>> 30);
  endfunction

  function automatic logic signed [31:0] neg32(input logic signed [31:0] x);
    return (x == 32'sh80000000) ? 32'sh7fffffff : -x;
  endfunction

  function automatic logic signed [31:0] qsat(input logic [DW-1:0] q, input logic neg);
    logic signed [65:0] e;
    e = $signed(66'(q));
    return sat32(neg ? -e : e);
  endfunction

  function automatic logic signed [32:0] sx(input logic signed [31:0] x);
    return 33'(x);
  endfunction

  // configuration
  logic [30:0]        fx_r, fy_r;
  logic signed [31:0] cx_r, cy_r;
  logic signed [32:0] fx33, fy33;

  assign cfg_ready = 1'b1;
  assign fx33 = $signed({2'b00, fx_r});
  assign fy33 = $signed({2'b00, fy_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= FOCAL_RST;
      fy_r <= FOCAL_RST;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        prrj_pkg::REG_FOCAL_X:  fx_r <= cfg_data[30:0];
        prrj_pkg::REG_FOCAL_Y:  fy_r <= cfg_data[30:0];
        prrj_pkg::REG_CENTER_X: cx_r <= $signed(cfg_data);
        prrj_pkg::REG_CENTER_Y: cy_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // handshake
  logic hv_r;
  logic [3:0] cnt_r;
  logic out_tvalid_r;
  logic out_load, emit, adv;

  assign out_load  = !out_tvalid_r || out_tready;
  assign emit      = hv_r && out_load;
  assign adv       = !hv_r || (emit && cnt_r == prrj_pkg::LAST_IDX);
  assign in_tready = adv;

  // input fields
  logic signed [31:0] qw, qx, qy, qz, mu_in, mv_in;
  logic signed [31:0] t_in [3];
  logic signed [31:0] p_in [3];

  always_comb begin
    qw = $signed(in_tdata[31:0]);
    qx = $signed(in_tdata[63:32]);
    qy = $signed(in_tdata[95:64]);
    qz = $signed(in_tdata[127:96]);
    for (int i = 0; i < 3; i++) begin
      t_in[i] = $signed(in_tdata[128 + 32*i +: 32]);
      p_in[i] = $signed(in_tdata[224 + 32*i +: 32]);
    end
    mu_in = $signed(in_tdata[351:320]);
    mv_in = $signed(in_tdata[383:352]);
  end

  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;

  // stage A: quaternion products
  logic signed [33:0] xx_a_r, yy_a_r, zz_a_r, xy_a_r, xz_a_r, yz_a_r;
  logic signed [33:0] wx_a_r, wy_a_r, wz_a_r;
  logic signed [31:0] t_a_r [3];
  logic signed [31:0] p_a_r [3];
  logic signed [31:0] mu_a_r, mv_a_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_a_r <= qmul(qx, qx);
      yy_a_r <= qmul(qy, qy);
      zz_a_r <= qmul(qz, qz);
      xy_a_r <= qmul(qx, qy);
      xz_a_r <= qmul(qx, qz);
      yz_a_r <= qmul(qy, qz);
      wx_a_r <= qmul(qw, qx);
      wy_a_r <= qmul(qw, qy);
      wz_a_r <= qmul(qw, qz);
      for (int i = 0; i < 3; i++) begin
        t_a_r[i] <= t_in[i];
        p_a_r[i] <= p_in[i];
      end
      mu_a_r <= mu_in;
      mv_a_r <= mv_in;
    end
  end

  // stage B: rotation matrix
  logic signed [31:0] r_b_r [3][3];
  logic signed [31:0] t_b_r [3];
  logic signed [31:0] p_b_r [3];
  logic signed [31:0] mu_b_r, mv_b_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r_b_r[0][0] <= sat32(ONE30 - 66'sd2 * (66'(yy_a_r) + 66'(zz_a_r)));
      r_b_r[0][1] <= sat32(66'sd2 * (66'(xy_a_r) - 66'(wz_a_r)));
      r_b_r[0][2] <= sat32(66'sd2 * (66'(xz_a_r) + 66'(wy_a_r)));
      r_b_r[1][0] <= sat32(66'sd2 * (66'(xy_a_r) + 66'(wz_a_r)));
      r_b_r[1][1] <= sat32(ONE30 - 66'sd2 * (66'(xx_a_r) + 66'(zz_a_r)));
      r_b_r[1][2] <= sat32(66'sd2 * (66'(yz_a_r) - 66'(wx_a_r)));
      r_b_r[2][0] <= sat32(66'sd2 * (66'(xz_a_r) - 66'(wy_a_r)));
      r_b_r[2][1] <= sat32(66'sd2 * (66'(yz_a_r) + 66'(wx_a_r)));
      r_b_r[2][2] <= sat32(ONE30 - 66'sd2 * (66'(xx_a_r) + 66'(yy_a_r)));
      t_b_r  <= t_a_r;
      p_b_r  <= p_a_r;
      mu_b_r <= mu_a_r;
      mv_b_r <= mv_a_r;
    end
  end

  // stage C: rotated point products
  logic signed [33:0] rp_c_r [3][3];
  logic signed [31:0] r_c_r  [3][3];
  logic signed [31:0] t_c_r  [3];
  logic signed [31:0] mu_c_r, mv_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) rp_c_r[i][j] <= qmul(r_b_r[i][j], p_b_r[j]);
      end
      r_c_r  <= r_b_r;
      t_c_r  <= t_b_r;
      mu_c_r <= mu_b_r;
      mv_c_r <= mv_b_r;
    end
  end

  // stage D: camera point
  logic signed [31:0] c_d_r [3];
  logic               bad_d_r;
  logic signed [31:0] r_d_r [3][3];
  logic signed [31:0] mu_d_r, mv_d_r;
  logic signed [31:0] c_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_nxt[i] = sat32(66'(t_c_r[i]) + 66'(rp_c_r[i][0]) + 66'(rp_c_r[i][1])
                       + 66'(rp_c_r[i][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_d_r   <= c_nxt;
      bad_d_r <= c_nxt[2] <= 32'sd0;
      r_d_r   <= r_c_r;
      mu_d_r  <= mu_c_r;
      mv_d_r  <= mv_c_r;
    end
  end

  // divider
  logic [2:0][DW-1:0] div_num, div_quo;
  logic [31:0]        div_den;
  logic [31:0]        mag0, mag1;
  prrj_pkg::div_pay_t div_in_pay, div_out_pay;
  logic               div_out_valid;

  always_comb begin
    mag0 = c_d_r[0][31] ? (~c_d_r[0] + 32'd1) : c_d_r[0];
    mag1 = c_d_r[1][31] ? (~c_d_r[1] + 32'd1) : c_d_r[1];
    div_num[0] = DW'(mag0) << FRAC_BITS;
    div_num[1] = DW'(mag1) << FRAC_BITS;
    div_num[2] = DW'(1) << (2 * FRAC_BITS);
    div_den    = bad_d_r ? 32'd1 : c_d_r[2];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) div_in_pay.r[3*i + j] = r_d_r[i][j];
    end
    div_in_pay.mu    = mu_d_r;
    div_in_pay.mv    = mv_d_r;
    div_in_pay.bad   = bad_d_r;
    div_in_pay.neg_a = c_d_r[0][31];
    div_in_pay.neg_b = c_d_r[1][31];
  end

  prrj_div #(
    .W(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (vd_r),
    .num      (div_num),
    .den      (div_den),
    .in_pay   (div_in_pay),
    .out_valid(div_out_valid),
    .quo      (div_quo),
    .out_pay  (div_out_pay)
  );

  // stage E: quotients
  logic signed [31:0] a_e_r, b_e_r, inv_e_r, mu_e_r, mv_e_r;
  logic [8:0][31:0]   r_e_r;
  logic               bad_e_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_e_r   <= qsat(div_quo[0], div_out_pay.neg_a);
      b_e_r   <= qsat(div_quo[1], div_out_pay.neg_b);
      inv_e_r <= qsat(div_quo[2], 1'b0);
      r_e_r   <= div_out_pay.r;
      mu_e_r  <= div_out_pay.mu;
      mv_e_r  <= div_out_pay.mv;
      bad_e_r <= div_out_pay.bad;
    end
  end

  // stage F: first products
  logic signed [31:0] fxa_f_r, fyb_f_r, ab_f_r, aa_f_r, bb_f_r, ainv_f_r, binv_f_r;
  logic signed [31:0] gu_f_r, gv_f_r, fxb_f_r, fya_f_r, mu_f_r, mv_f_r;
  logic signed [31:0] ar2_f_r [3];
  logic signed [31:0] br2_f_r [3];
  logic signed [31:0] rs0_f_r [3];
  logic signed [31:0] rs1_f_r [3];
  logic               bad_f_r;
  logic signed [31:0] rs [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) rs[i][j] = $signed(r_e_r[3*i + j]) >>> RSH;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fxa_f_r  <= mulf(fx33, sx(a_e_r));
      fyb_f_r  <= mulf(fy33, sx(b_e_r));
      ab_f_r   <= mulf(sx(a_e_r), sx(b_e_r));
      aa_f_r   <= mulf(sx(a_e_r), sx(a_e_r));
      bb_f_r   <= mulf(sx(b_e_r), sx(b_e_r));
      ainv_f_r <= mulf(sx(a_e_r), sx(inv_e_r));
      binv_f_r <= mulf(sx(b_e_r), sx(inv_e_r));
      gu_f_r   <= mulf(fx33, sx(inv_e_r));
      gv_f_r   <= mulf(fy33, sx(inv_e_r));
      fxb_f_r  <= mulf(fx33, sx(b_e_r));
      fya_f_r  <= mulf(fy33, sx(a_e_r));
      for (int j = 0; j < 3; j++) begin
        ar2_f_r[j] <= mulf(sx(a_e_r), sx(rs[2][j]));
        br2_f_r[j] <= mulf(sx(b_e_r), sx(rs[2][j]));
        rs0_f_r[j] <= rs[0][j];
        rs1_f_r[j] <= rs[1][j];
      end
      mu_f_r  <= mu_e_r;
      mv_f_r  <= mv_e_r;
      bad_f_r <= bad_e_r;
    end
  end

  // stage G: sums
  logic signed [31:0] pu_g_r, pv_g_r, aa1_g_r, bb1_g_r;
  logic signed [31:0] ab_g_r, ainv_g_r, binv_g_r, gu_g_r, gv_g_r, fxb_g_r, fya_g_r;
  logic signed [31:0] mu_g_r, mv_g_r;
  logic signed [31:0] du_g_r [3];
  logic signed [31:0] dv_g_r [3];
  logic               bad_g_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pu_g_r  <= sat32(66'(fxa_f_r) + 66'(cx_r));
      pv_g_r  <= sat32(66'(fyb_f_r) + 66'(cy_r));
      aa1_g_r <= sat32(ONE + 66'(aa_f_r));
      bb1_g_r <= sat32(ONE + 66'(bb_f_r));
      for (int j = 0; j < 3; j++) begin
        du_g_r[j] <= sat32(66'(rs0_f_r[j]) - 66'(ar2_f_r[j]));
        dv_g_r[j] <= sat32(66'(rs1_f_r[j]) - 66'(br2_f_r[j]));
      end
      ab_g_r   <= ab_f_r;
      ainv_g_r <= ainv_f_r;
      binv_g_r <= binv_f_r;
      gu_g_r   <= gu_f_r;
      gv_g_r   <= gv_f_r;
      fxb_g_r  <= fxb_f_r;
      fya_g_r  <= fya_f_r;
      mu_g_r   <= mu_f_r;
      mv_g_r   <= mv_f_r;
      bad_g_r  <= bad_f_r;
    end
  end

  // stage H: second products and residual
  logic signed [31:0] resu_h_r, resv_h_r, p1u_h_r, p1v_h_r, p2u_h_r, p2v_h_r;
  logic signed [31:0] p6u_h_r, p6v_h_r, fxb_h_r, fya_h_r, gu_h_r, gv_h_r;
  logic signed [31:0] ju_h_r [3];
  logic signed [31:0] jv_h_r [3];
  logic               bad_h_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      resu_h_r <= sat32(66'(mu_g_r) - 66'(pu_g_r));
      resv_h_r <= sat32(66'(mv_g_r) - 66'(pv_g_r));
      p1u_h_r  <= mulf(fx33, sx(ab_g_r));
      p1v_h_r  <= mulf(fy33, sx(bb1_g_r));
      p2u_h_r  <= mulf(fx33, sx(aa1_g_r));
      p2v_h_r  <= mulf(fy33, sx(ab_g_r));
      p6u_h_r  <= mulf(fx33, sx(ainv_g_r));
      p6v_h_r  <= mulf(fy33, sx(binv_g_r));
      for (int j = 0; j < 3; j++) begin
        ju_h_r[j] <= mulf(sx(gu_g_r), sx(du_g_r[j]));
        jv_h_r[j] <= mulf(sx(gv_g_r), sx(dv_g_r[j]));
      end
      fxb_h_r <= fxb_g_r;
      fya_h_r <= fya_g_r;
      gu_h_r  <= gu_g_r;
      gv_h_r  <= gv_g_r;
      bad_h_r <= bad_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_tvalid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= div_out_valid;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
    end
  end

  // hold one item and serialize its ten results
  logic signed [31:0] hu_r [prrj_pkg::NUM_RES];
  logic signed [31:0] hw_r [prrj_pkg::NUM_RES];
  logic               hbad_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      hu_r[0] <= resu_h_r;          hw_r[0] <= resv_h_r;
      hu_r[1] <= p1u_h_r;           hw_r[1] <= p1v_h_r;
      hu_r[2] <= neg32(p2u_h_r);    hw_r[2] <= neg32(p2v_h_r);
      hu_r[3] <= fxb_h_r;           hw_r[3] <= neg32(fya_h_r);
      hu_r[4] <= neg32(gu_h_r);     hw_r[4] <= '0;
      hu_r[5] <= '0;                hw_r[5] <= neg32(gv_h_r);
      hu_r[6] <= p6u_h_r;           hw_r[6] <= p6v_h_r;
      for (int j = 0; j < 3; j++) begin
        hu_r[7 + j] <= neg32(ju_h_r[j]);
        hw_r[7 + j] <= neg32(jv_h_r[j]);
      end
      hbad_r <= bad_h_r;
    end
  end

  logic [1:0]         out_part_r;
  logic [2:0]         out_col_r;
  logic signed [31:0] out_u_r, out_v_r;
  logic               out_bad_r, out_last_r;
  logic [1:0]         part_nxt;
  logic [2:0]         col_nxt;

  always_comb begin
    priority if (cnt_r == 4'd0) begin
      part_nxt = prrj_pkg::PART_RES;
      col_nxt  = 3'd0;
    end else if (cnt_r < prrj_pkg::POINT_BASE) begin
      part_nxt = prrj_pkg::PART_POSE;
      col_nxt  = 3'(cnt_r - prrj_pkg::POSE_BASE);
    end else begin
      part_nxt = prrj_pkg::PART_POINT;
      col_nxt  = 3'(cnt_r - prrj_pkg::POINT_BASE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r         <= 1'b0;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (adv) hv_r <= vh_r;
      if (emit) cnt_r <= (cnt_r == prrj_pkg::LAST_IDX) ? 4'd0 : cnt_r + 4'd1;
      if (out_load) out_tvalid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_part_r <= part_nxt;
      out_col_r  <= col_nxt;
      out_u_r    <= hbad_r ? 32'sd0 : hu_r[cnt_r];
      out_v_r    <= hbad_r ? 32'sd0 : hw_r[cnt_r];
      out_bad_r  <= hbad_r;
      out_last_r <= cnt_r == prrj_pkg::LAST_IDX;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_v_r, out_u_r};
  assign out_tuser  = {2'b00, out_bad_r, out_col_r, out_part_r};
  assign out_tlast  = out_last_r;

  `PRRJ_ASSERT(a_cnt_range, cnt_r <= prrj_pkg::LAST_IDX, "result counter out of range")
  `PRRJ_ASSERT(a_idle_cnt, !hv_r |-> cnt_r == 4'd0, "counter moved with no item held")
  `PRRJ_ASSERT(a_last_point, out_tvalid_r && out_last_r |->
               out_part_r == prrj_pkg::PART_POINT && out_col_r == 3'd2, "last flag on wrong result")
  `PRRJ_ASSERT(a_bad_zero, out_tvalid_r && out_bad_r |->
               out_u_r == 32'sd0 && out_v_r == 32'sd0, "bad depth result not zeroed")
  `PRRJ_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid_r && !hv_r, "reset left results pending")

endmodule

@@ rtl/prrj_div.sv @@
module prrj_div #(
  parameter int W = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][W-1:0]   num,
  input  logic [31:0]         den,
  input  prrj_pkg::div_pay_t  in_pay,
  output logic                out_valid,
  output logic [2:0][W-1:0]   quo,
  output prrj_pkg::div_pay_t  out_pay
);

  logic               v_r   [W];
  logic [2:0][31:0]   rem_r [W];
  logic [2:0][W-1:0]  nq_r  [W];
  logic [31:0]        d_r   [W];
  prrj_pkg::div_pay_t pay_r [W];

  logic [2:0][31:0]   rem_nxt [W];
  logic [2:0][W-1:0]  nq_nxt  [W];

  always_comb begin
    logic [2:0][31:0]  rem_i;
    logic [2:0][W-1:0] nq_i;
    logic [31:0]       d_i;
    logic [32:0]       t;
    logic              ge;
    for (int k = 0; k < W; k++) begin
      if (k == 0) begin
        rem_i = '0;
        nq_i  = num;
        d_i   = den;
      end else begin
        rem_i = rem_r[k-1];
        nq_i  = nq_r[k-1];
        d_i   = d_r[k-1];
      end
      for (int l = 0; l < 3; l++) begin
        t  = {rem_i[l], nq_i[l][W-1]};
        ge = t >= {1'b0, d_i};
        rem_nxt[k][l] = ge ? 32'(t - {1'b0, d_i}) : t[31:0];
        nq_nxt[k][l]  = {nq_i[l][W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < W; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
      end
      d_r[0]   <= den;
      pay_r[0] <= in_pay;
      for (int k = 1; k < W; k++) begin
        d_r[k]   <= d_r[k-1];
        pay_r[k] <= pay_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < W; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < W; k++) v_r[k] <= v_r[k-1];
    end
  end

  assign out_valid = v_r[W-1];
  assign quo       = nq_r[W-1];
  assign out_pay   = pay_r[W-1];

endmodule

@@ verif/pinhole_reprojection_residual_jacobian_checker.sv @@
`timescale 1ns / 100ps

module pinhole_reprojection_residual_jacobian_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [383:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [7:0]   out_tuser,
  input  logic         out_tlast,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           result_count
);

  typedef struct {
    logic [1:0]  part;
    logic [2:0]  column;
    logic [31:0] value_u;
    logic [31:0] value_v;
    logic        bad_depth;
    logic        last;
  } jac_entry_t;

  jac_entry_t jac_queue[$];
  longint     focal_x, focal_y, center_x, center_y;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(longint p, longint q);
    return clamp32((p * q) >>> FRAC_BITS);
  endfunction

  function automatic longint qmul(longint p, longint q);
    return (p * q) >>> 30;
  endfunction

  function automatic longint field(logic [383:0] d, int k);
    return longint'($signed(d[32*k +: 32]));
  endfunction

  function automatic void push_entry(int k, logic [1:0] part, int col, longint vu, longint vv,
                                     bit bad);
    jac_entry_t e;
    e.part      = part;
    e.column    = col[2:0];
    e.value_u   = bad ? 32'd0 : vu[31:0];
    e.value_v   = bad ? 32'd0 : vv[31:0];
    e.bad_depth = bad;
    e.last      = (k == prrj_pkg::NUM_RES - 1);
    jac_queue.push_back(e);
  endfunction

  function automatic void predict_jacobians(logic [383:0] d);
    longint one30, one, qw, qx, qy, qz, s, a, b, inv, pu, pv;
    longint ab, aa1, bb1, ainv, binv, gu, gv, r0, r1, r2, du, dv;
    longint r[3][3];
    longint c[3];
    bit     bad;
    one30 = 64'sd1 <<< 30;
    one   = 64'sd1 <<< FRAC_BITS;
    qw = field(d, 0); qx = field(d, 1); qy = field(d, 2); qz = field(d, 3);
    r[0][0] = clamp32(one30 - 2 * (qmul(qy, qy) + qmul(qz, qz)));
    r[0][1] = clamp32(2 * (qmul(qx, qy) - qmul(qw, qz)));
    r[0][2] = clamp32(2 * (qmul(qx, qz) + qmul(qw, qy)));
    r[1][0] = clamp32(2 * (qmul(qx, qy) + qmul(qw, qz)));
    r[1][1] = clamp32(one30 - 2 * (qmul(qx, qx) + qmul(qz, qz)));
    r[1][2] = clamp32(2 * (qmul(qy, qz) - qmul(qw, qx)));
    r[2][0] = clamp32(2 * (qmul(qx, qz) - qmul(qw, qy)));
    r[2][1] = clamp32(2 * (qmul(qy, qz) + qmul(qw, qx)));
    r[2][2] = clamp32(one30 - 2 * (qmul(qx, qx) + qmul(qy, qy)));
    for (int i = 0; i < 3; i++) begin
      s = field(d, 4 + i);
      for (int j = 0; j < 3; j++) s += (r[i][j] * field(d, 7 + j)) >>> 30;
      c[i] = clamp32(s);
    end
    bad = (c[2] <= 0);
    a = 0; b = 0; inv = 0;
    if (!bad) begin
      a   = clamp32((c[0] * one) / c[2]);
      b   = clamp32((c[1] * one) / c[2]);
      inv = clamp32((one * one) / c[2]);
    end
    pu = clamp32(fmul(focal_x, a) + center_x);
    pv = clamp32(fmul(focal_y, b) + center_y);
    push_entry(0, prrj_pkg::PART_RES, 0, clamp32(field(d, 10) - pu),
               clamp32(field(d, 11) - pv), bad);
    ab   = fmul(a, b);
    aa1  = clamp32(one + fmul(a, a));
    bb1  = clamp32(one + fmul(b, b));
    ainv = fmul(a, inv);
    binv = fmul(b, inv);
    push_entry(1, prrj_pkg::PART_POSE, 0, fmul(focal_x, ab), fmul(focal_y, bb1), bad);
    push_entry(2, prrj_pkg::PART_POSE, 1, clamp32(-fmul(focal_x, aa1)),
               clamp32(-fmul(focal_y, ab)), bad);
    push_entry(3, prrj_pkg::PART_POSE, 2, fmul(focal_x, b), clamp32(-fmul(focal_y, a)), bad);
    push_entry(4, prrj_pkg::PART_POSE, 3, clamp32(-fmul(focal_x, inv)), 0, bad);
    push_entry(5, prrj_pkg::PART_POSE, 4, 0, clamp32(-fmul(focal_y, inv)), bad);
    push_entry(6, prrj_pkg::PART_POSE, 5, fmul(focal_x, ainv), fmul(focal_y, binv), bad);
    gu = fmul(focal_x, inv);
    gv = fmul(focal_y, inv);
    for (int j = 0; j < 3; j++) begin
      r0 = r[0][j] >>> (30 - FRAC_BITS);
      r1 = r[1][j] >>> (30 - FRAC_BITS);
      r2 = r[2][j] >>> (30 - FRAC_BITS);
      du = clamp32(r0 - fmul(a, r2));
      dv = clamp32(r1 - fmul(b, r2));
      push_entry(7 + j, prrj_pkg::PART_POINT, j, clamp32(-fmul(gu, du)),
                 clamp32(-fmul(gv, dv)), bad);
    end
  endfunction

  assign pending = jac_queue.size();

  always @(posedge clk) begin
    jac_entry_t e;
    if (!rst_n) begin
      focal_x      <= longint'(500) <<< FRAC_BITS;
      focal_y      <= longint'(500) <<< FRAC_BITS;
      center_x     <= 0;
      center_y     <= 0;
      fail_count   <= 0;
      result_count <= 0;
      jac_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          prrj_pkg::REG_FOCAL_X:  focal_x  <= longint'(cfg_data[30:0]);
          prrj_pkg::REG_FOCAL_Y:  focal_y  <= longint'(cfg_data[30:0]);
          prrj_pkg::REG_CENTER_X: center_x <= longint'($signed(cfg_data));
          prrj_pkg::REG_CENTER_Y: center_y <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (jac_queue.size() == 0) begin
          $display("%0t: unexpected result tuser=%h tdata=%h", $realtime, out_tuser, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = jac_queue.pop_front();
          if (out_tuser[1:0] !== e.part || out_tuser[4:2] !== e.column ||
              out_tdata[31:0] !== e.value_u || out_tdata[63:32] !== e.value_v ||
              out_tuser[5] !== e.bad_depth || out_tlast !== e.last) begin
            $display("%0t: mismatch expected part=%0d col=%0d u=%h v=%h bad=%b last=%b",
                     $realtime, e.part, e.column, e.value_u, e.value_v, e.bad_depth, e.last);
            $display("%0t:          actual   part=%0d col=%0d u=%h v=%h bad=%b last=%b",
                     $realtime, out_tuser[1:0], out_tuser[4:2], out_tdata[31:0],
                     out_tdata[63:32], out_tuser[5], out_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_jacobians(in_tdata);
    end
  end

endmodule

@@ verif/pinhole_reprojection_residual_jacobian_top_test.sv @@
`timescale 1ns / 100ps

module pinhole_reprojection_residual_jacobian_top_test;

  localparam int         FRAC_BITS  = 16;
  localparam logic [7:0] REG_UNUSED = 8'd7;
  localparam int         IDLE_LIMIT = 20000;
  localparam int         DRAIN      = 80;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [383:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [7:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  int fail_count, pending, result_count;
  int item_count = 0;
  int cfg_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  pinhole_reprojection_residual_jacobian_top #(.FRAC_BITS(FRAC_BITS)) i_dut (.*);

  pinhole_reprojection_residual_jacobian_checker #(.FRAC_BITS(FRAC_BITS)) i_checker (.*);

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
      $display("pinhole_reprojection_residual_jacobian_top_test: FAIL");
      $finish;
    end
  end

  function automatic logic [383:0] pose_item(logic [31:0] qw, logic [31:0] qx, logic [31:0] qy,
                                             logic [31:0] qz, logic [31:0] tx, logic [31:0] ty,
                                             logic [31:0] tz, logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [31:0] mu, logic [31:0] mv);
    return {mv, mu, pz, py, px, tz, ty, tx, qz, qy, qx, qw};
  endfunction

  function automatic logic [31:0] spread(int mag);
    return $unsigned($signed($urandom_range(0, 2 * mag)) - mag);
  endfunction

  function automatic logic [383:0] random_pose();
    logic [383:0] d;
    if ($urandom_range(0, 99) < 20) begin
      for (int k = 0; k < 12; k++) d[32*k +: 32] = $urandom();
    end else begin
      d = pose_item(32'h4000_0000 - $urandom_range(0, 1 << 28), spread(1 << 29),
                    spread(1 << 29), spread(1 << 29), spread(1 << 20), spread(1 << 20),
                    $urandom_range(0, 1 << 21), spread(1 << 22), spread(1 << 22),
                    $urandom_range(1, 1 << 23), spread(1 << 27), spread(1 << 27));
    end
    return d;
  endfunction

  task automatic send_item(logic [383:0] d);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    item_count++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(pose_item(32'h4000_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0002_0000,
                        32'h000a_0000, 32'h0032_0000, 32'h0064_0000));
    send_item(pose_item(32'h4000_0000, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
    send_item(pose_item(32'h4000_0000, 0, 0, 0, 0, 0, 32'hfff0_0000, 0, 0, 32'h0001_0000,
                        0, 0));
    send_item(pose_item(32'h4000_0000, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1,
                        0, 0));
    send_item(pose_item(0, 32'h4000_0000, 0, 0, 0, 0, 0, 32'h0003_0000, 32'h0001_0000,
                        32'hfffb_0000, 32'h7fff_ffff, 32'h8000_0000));
    send_item(pose_item(32'h2d41_3ccd, 0, 32'h2d41_3ccd, 0, 32'h0000_8000, 32'hffff_0000,
                        32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000,
                        32'h8000_0000, 32'h7fff_ffff));
    send_item('0);
    send_item({12{32'h7fff_ffff}});
    send_item({12{32'h8000_0000}});
    send_item({12{32'h5555_5555}});
    send_item({12{32'haaaa_aaaa}});
    send_item(pose_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        0, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0));
    send_item(pose_item(32'h4000_0000, 0, 0, 0, 32'h7fff_0000, 32'h8000_0000, 32'h0000_0001,
                        0, 0, 0, 0, 0));

    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            write_reg(prrj_pkg::REG_FOCAL_X, 32'hffff_ffff);
            write_reg(prrj_pkg::REG_FOCAL_Y, 32'h0000_0000);
            write_reg(prrj_pkg::REG_CENTER_X, 32'h8000_0000);
            write_reg(prrj_pkg::REG_CENTER_Y, 32'h7fff_ffff);
            write_reg(REG_UNUSED, $urandom());
          end
          2: begin
            calm = 1'b1;
            write_reg(prrj_pkg::REG_FOCAL_X, 32'h0000_0000);
            write_reg(prrj_pkg::REG_FOCAL_Y, 32'h7fff_ffff);
            write_reg(prrj_pkg::REG_CENTER_X, 32'h7fff_ffff);
            write_reg(prrj_pkg::REG_CENTER_Y, 32'h8000_0000);
          end
          default: begin
            calm = 1'b0;
            write_reg(prrj_pkg::REG_FOCAL_X,
                      $urandom_range(100, 2000) << FRAC_BITS | $urandom_range(0, 65535));
            write_reg(prrj_pkg::REG_FOCAL_Y,
                      $urandom_range(100, 2000) << FRAC_BITS | $urandom_range(0, 65535));
            write_reg(prrj_pkg::REG_CENTER_X, spread(1 << 26));
            write_reg(prrj_pkg::REG_CENTER_Y, spread(1 << 26));
          end
        endcase
      end
      for (int n = 0; n < 75; n++) send_item(random_pose());
    end
    settle();

    $display("ran %0d items through four register settings (%0d writes), %0d results checked",
             item_count, cfg_count, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("pinhole_reprojection_residual_jacobian_top_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("pinhole_reprojection_residual_jacobian_top_test: FAIL");
    end
    $finish;
  end

endmodule
